FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset
`define FBSP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check an implication on every clock edge, reset included
`define FBSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: rtl/fbsp_pkg.sv
// Shared types and constants of the frame buffer slot pool
package fbsp_pkg;
    localparam int MAX_SLOTS = 8;
    localparam int MIN_SLOTS = 3;
    localparam int COUNTER_WIDTH = 32;
    localparam int IDX_W = 3;
    localparam int CNT_W = 4;

    typedef enum logic [2:0] {
        ST_AVAIL  = 3'd0,
        ST_FLIGHT = 3'd1,
        ST_DONE   = 3'd2,
        ST_SHOWN  = 3'd3,
        ST_HELD   = 3'd4
    } slot_tag_t;

    typedef enum logic [2:0] {
        MODE_ACQUIRE  = 3'd0,
        MODE_COMPLETE = 3'd1,
        MODE_RELEASE  = 3'd2,
        MODE_DISPLAY  = 3'd3,
        MODE_PROTECT  = 3'd4,
        MODE_INSTALL  = 3'd5,
        MODE_CLEAR    = 3'd6,
        MODE_QUERY    = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        REG_TARGET_COUNT  = 3'd0,
        REG_INIT_DISP     = 3'd1,
        REG_INIT_DISP_P   = 3'd2,
        REG_INIT_PROT     = 3'd3,
        REG_INIT_PROT_P   = 3'd4
    } reg_idx_t;

    // Command from controller to datapath
    typedef struct packed {
        logic   exec;
        mode_t  mode;
        logic [IDX_W-1:0] slot;
        logic   handle;
        logic   success;
    } fbsp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic   done;
    } fbsp_stat_t;

    typedef struct packed {
        logic [COUNTER_WIDTH-1:0] generation;
        logic [COUNTER_WIDTH-1:0] stall_total;
        logic [COUNTER_WIDTH-1:0] miss_total;
        logic [COUNTER_WIDTH-1:0] rel_total;
        logic [COUNTER_WIDTH-1:0] comp_total;
        logic [COUNTER_WIDTH-1:0] acq_total;
        logic [CNT_W-1:0] n_drawn;
        logic [CNT_W-1:0] n_busy;
        logic [CNT_W-1:0] n_free;
        logic             installed;
        logic [IDX_W-1:0] granted_slot;
        logic             ok;
    } fbsp_result_t;

    typedef struct packed {
        logic [CNT_W-1:0] ring_target;
        logic [IDX_W-1:0] init_disp;
        logic             init_disp_p;
        logic [IDX_W-1:0] init_prot;
        logic             init_prot_p;
    } fbsp_cfg_t;
endpackage

FILE: rtl/fbsp_ctrl.sv
// Controller: input/output handshake sequencing
module fbsp_ctrl import fbsp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [IDX_W+4:0] in_data,
    output fbsp_cmd_t  cmd,
    input  fbsp_stat_t stat,
    output logic       out_valid,
    input  logic       out_ready
);
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_OUT  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Accept while idle or while the held result leaves this cycle
    assign in_ready  = (state_reg == S_IDLE) || out_ready;
    assign out_valid = (state_reg == S_OUT);

    always_comb begin
        cmd.exec    = in_valid && in_ready;
        cmd.mode    = mode_t'(in_data[2:0]);
        cmd.slot    = in_data[IDX_W+2:3];
        cmd.handle  = in_data[IDX_W+3];
        cmd.success = in_data[IDX_W+4];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (stat.done) state_next = S_OUT;
            S_OUT: begin
                if (stat.done) state_next = S_OUT;
                else if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end
endmodule

FILE: rtl/fbsp_datapath.sv
// Datapath: slot tags, ring state, event counters and result register
module fbsp_datapath import fbsp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  fbsp_cmd_t    cmd,
    input  fbsp_cfg_t    cfg,
    output fbsp_stat_t   stat,
    output fbsp_result_t result
);
    slot_tag_t tag_reg [MAX_SLOTS];
    slot_tag_t tag_next [MAX_SLOTS];
    logic [CNT_W-1:0] active_reg, active_next;
    logic [IDX_W-1:0] shown_idx_reg, shown_idx_next, held_idx_reg, held_idx_next;
    logic shown_v_reg, shown_v_next, held_v_reg, held_v_next;
    logic [COUNTER_WIDTH-1:0] acq_reg, comp_reg, rel_reg, miss_reg, back_reg, gen_reg;
    logic inc_acq, inc_comp, inc_rel, inc_miss, inc_back, inc_gen;
    fbsp_result_t res_reg;
    logic ok;
    logic [IDX_W-1:0] granted;
    logic [MAX_SLOTS-1:0] in_ring, avail_vec;
    logic found;
    logic retag;
    logic slot_in;
    logic [CNT_W-1:0] n_av, n_fl, n_dn;

    function automatic slot_tag_t home(input logic [IDX_W-1:0] i,
                                       input logic sv, input logic [IDX_W-1:0] si,
                                       input logic hv, input logic [IDX_W-1:0] hi);
        if (sv && si == i) return ST_SHOWN;
        if (hv && hi == i) return ST_HELD;
        return ST_AVAIL;
    endfunction

    always_comb begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            in_ring[i]   = CNT_W'(i) < active_reg;
            avail_vec[i] = in_ring[i] && tag_reg[i] == ST_AVAIL;
        end
    end

    // Lowest available slot
    always_comb begin
        found   = 1'b0;
        granted = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (avail_vec[i]) begin
                found   = 1'b1;
                granted = IDX_W'(i);
            end
        end
    end

    assign slot_in = {1'b0, cmd.slot} < active_reg;

    always_comb begin
        tag_next = tag_reg;
        active_next = active_reg;
        shown_idx_next = shown_idx_reg;
        shown_v_next = shown_v_reg;
        held_idx_next = held_idx_reg;
        held_v_next = held_v_reg;
        {inc_acq, inc_comp, inc_rel, inc_miss, inc_back, inc_gen} = '0;
        ok = 1'b0;
        retag = 1'b0;
        case (cmd.mode)
            MODE_ACQUIRE: begin
                if (found) begin
                    tag_next[granted] = ST_FLIGHT;
                    inc_acq = 1'b1;
                    ok = 1'b1;
                end else begin
                    inc_back = 1'b1;
                end
            end
            MODE_COMPLETE: begin
                if (cmd.handle && slot_in && tag_reg[cmd.slot] == ST_FLIGHT) begin
                    if (cmd.success) begin
                        tag_next[cmd.slot] = ST_DONE;
                        inc_comp = 1'b1;
                    end else begin
                        tag_next[cmd.slot] = home(cmd.slot, shown_v_reg, shown_idx_reg,
                                                  held_v_reg, held_idx_reg);
                    end
                    ok = 1'b1;
                end
            end
            MODE_RELEASE: begin
                if (cmd.handle) begin
                    if (slot_in && tag_reg[cmd.slot] == ST_DONE) begin
                        inc_rel = 1'b1;
                        tag_next[cmd.slot] = home(cmd.slot, shown_v_reg, shown_idx_reg,
                                                  held_v_reg, held_idx_reg);
                        ok = 1'b1;
                    end else begin
                        inc_miss = 1'b1;
                    end
                end
            end
            MODE_DISPLAY: begin
                if (cmd.handle && slot_in) begin
                    shown_idx_next = cmd.slot;
                    shown_v_next = 1'b1;
                    retag = 1'b1;
                    ok = 1'b1;
                end
            end
            MODE_PROTECT: begin
                if (!cmd.handle) begin
                    held_v_next = 1'b0;
                    held_idx_next = '0;
                    retag = 1'b1;
                    ok = 1'b1;
                end else if (slot_in) begin
                    held_idx_next = cmd.slot;
                    held_v_next = 1'b1;
                    retag = 1'b1;
                    ok = 1'b1;
                end
            end
            MODE_INSTALL: begin
                if (cfg.ring_target >= CNT_W'(MIN_SLOTS) &&
                    cfg.ring_target <= CNT_W'(MAX_SLOTS) &&
                    !(cfg.init_disp_p && {1'b0, cfg.init_disp} >= cfg.ring_target) &&
                    !(cfg.init_prot_p && {1'b0, cfg.init_prot} >= cfg.ring_target)) begin
                    active_next = cfg.ring_target;
                    shown_v_next = cfg.init_disp_p;
                    shown_idx_next = cfg.init_disp_p ? cfg.init_disp : '0;
                    held_v_next = cfg.init_prot_p;
                    held_idx_next = cfg.init_prot_p ? cfg.init_prot : '0;
                    for (int i = 0; i < MAX_SLOTS; i++) begin
                        tag_next[i] = (CNT_W'(i) < cfg.ring_target)
                            ? home(IDX_W'(i), cfg.init_disp_p, cfg.init_disp,
                                   cfg.init_prot_p, cfg.init_prot)
                            : ST_AVAIL;
                    end
                    inc_gen = 1'b1;
                    ok = 1'b1;
                end
            end
            MODE_CLEAR: begin
                for (int i = 0; i < MAX_SLOTS; i++) tag_next[i] = ST_AVAIL;
                active_next = '0;
                shown_idx_next = '0;
                shown_v_next = 1'b0;
                held_idx_next = '0;
                held_v_next = 1'b0;
                inc_gen = 1'b1;
                ok = 1'b1;
            end
            default: ok = 1'b1;
        endcase
        // Re-tag in-ring slots not in flight: the new shown/held slots take that tag, old ones return to available
        if (retag) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                if (in_ring[i] && tag_reg[i] != ST_FLIGHT) begin
                    if (home(IDX_W'(i), shown_v_next, shown_idx_next,
                             held_v_next, held_idx_next) != ST_AVAIL)
                        tag_next[i] = home(IDX_W'(i), shown_v_next, shown_idx_next,
                                           held_v_next, held_idx_next);
                    else if (tag_reg[i] == ST_SHOWN || tag_reg[i] == ST_HELD)
                        tag_next[i] = ST_AVAIL;
                end
            end
        end
    end

    // Tally tags of the new state
    always_comb begin
        n_av = '0;
        n_fl = '0;
        n_dn = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (CNT_W'(i) < active_next) begin
                if (tag_next[i] == ST_AVAIL) n_av = n_av + 1'b1;
                if (tag_next[i] == ST_FLIGHT) n_fl = n_fl + 1'b1;
                if (tag_next[i] == ST_DONE) n_dn = n_dn + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SLOTS; i++) tag_reg[i] <= ST_AVAIL;
            active_reg <= '0;
            shown_idx_reg <= '0;
            shown_v_reg <= 1'b0;
            held_idx_reg <= '0;
            held_v_reg <= 1'b0;
            acq_reg <= '0;
            comp_reg <= '0;
            rel_reg <= '0;
            miss_reg <= '0;
            back_reg <= '0;
            gen_reg <= '0;
        end else if (cmd.exec) begin
            tag_reg <= tag_next;
            active_reg <= active_next;
            shown_idx_reg <= shown_idx_next;
            shown_v_reg <= shown_v_next;
            held_idx_reg <= held_idx_next;
            held_v_reg <= held_v_next;
            acq_reg <= acq_reg + COUNTER_WIDTH'(inc_acq);
            comp_reg <= comp_reg + COUNTER_WIDTH'(inc_comp);
            rel_reg <= rel_reg + COUNTER_WIDTH'(inc_rel);
            miss_reg <= miss_reg + COUNTER_WIDTH'(inc_miss);
            back_reg <= back_reg + COUNTER_WIDTH'(inc_back);
            gen_reg <= gen_reg + COUNTER_WIDTH'(inc_gen);
        end
    end

    // Capture the result of the executed operation
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_reg.ok <= ok;
            res_reg.granted_slot <= (cmd.mode == MODE_ACQUIRE && found) ? granted : '0;
            res_reg.installed <= active_next >= CNT_W'(MIN_SLOTS);
            res_reg.n_free <= n_av;
            res_reg.n_busy <= n_fl;
            res_reg.n_drawn <= n_dn;
            res_reg.acq_total <= acq_reg + COUNTER_WIDTH'(inc_acq);
            res_reg.comp_total <= comp_reg + COUNTER_WIDTH'(inc_comp);
            res_reg.rel_total <= rel_reg + COUNTER_WIDTH'(inc_rel);
            res_reg.miss_total <= miss_reg + COUNTER_WIDTH'(inc_miss);
            res_reg.stall_total <= back_reg + COUNTER_WIDTH'(inc_back);
            res_reg.generation <= gen_reg + COUNTER_WIDTH'(inc_gen);
        end
    end

    assign stat.done = cmd.exec;
    assign result = res_reg;
endmodule

FILE: rtl/frame_buffer_slot_pool.sv
// Top level of the frame buffer slot pool
// Each operation executes in the cycle of its transfer and its result is
// registered, so one operation is taken per clock unless m_tready holds the
// result; the next is accepted while the previous result leaves. The eight slot
// tags are scanned side by side by a priority encoder. Configuration registers
// feed install only and are written over APB at byte addresses 0,4,..,16.
`include "assert_macros.svh"
module frame_buffer_slot_pool import fbsp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[2:0], slot[5:3], handle_present[6], success[7]
    input  logic [7:0]   s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // ok[0], granted_slot[3:1], installed[4], free slots[8:5], busy slots[12:9],
    // drawn slots[16:13], acquires[48:17], completions[80:49], releases[112:81],
    // release misses[144:113], stalled acquires[176:145], generation[208:177];
    // zero filled to 216
    output logic [215:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    fbsp_cmd_t    cmd;
    fbsp_stat_t   stat;
    fbsp_result_t result;
    fbsp_cfg_t    cfg_reg;
    logic         wr;
    reg_idx_t     ridx;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign ridx = reg_idx_t'(paddr[4:2]);

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr && paddr[1:0] == 2'b00) begin
            unique case (ridx)
                REG_TARGET_COUNT: cfg_reg.ring_target <= pwdata[CNT_W-1:0];
                REG_INIT_DISP:    cfg_reg.init_disp <= pwdata[IDX_W-1:0];
                REG_INIT_DISP_P:  cfg_reg.init_disp_p <= pwdata[0];
                REG_INIT_PROT:    cfg_reg.init_prot <= pwdata[IDX_W-1:0];
                REG_INIT_PROT_P:  cfg_reg.init_prot_p <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        prdata = '0;
        unique case (ridx)
            REG_TARGET_COUNT: prdata = 32'(cfg_reg.ring_target);
            REG_INIT_DISP:    prdata = 32'(cfg_reg.init_disp);
            REG_INIT_DISP_P:  prdata = 32'(cfg_reg.init_disp_p);
            REG_INIT_PROT:    prdata = 32'(cfg_reg.init_prot);
            REG_INIT_PROT_P:  prdata = 32'(cfg_reg.init_prot_p);
            default:          prdata = '0;
        endcase
    end

    fbsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_valid(m_tvalid),
        .out_ready(m_tready)
    );

    fbsp_datapath u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .cfg    (cfg_reg),
        .stat   (stat),
        .result (result)
    );

    assign m_tdata = {7'd0, result};

    `FBSP_ASSERT(a_ready_when_idle, aclk, aresetn, !m_tvalid |-> s_tready, "ready dropped while idle")
    `FBSP_ASSERT(a_result_follows, aclk, aresetn, (s_tvalid && s_tready) |=> m_tvalid, "no result after transfer")
    `FBSP_ASSERT(a_grant_ok, aclk, aresetn, (m_tvalid && m_tdata[3:1] != 3'd0) |-> m_tdata[0], "grant without ok")
endmodule
